// ===== rtl/task_slot_round_robin_core_assert.svh =====
// Assertion macros shared by the task slot scheduler RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef TASK_SLOT_ROUND_ROBIN_CORE_ASSERT_SVH
`define TASK_SLOT_ROUND_ROBIN_CORE_ASSERT_SVH

`ifndef SYNTH
`define TSRR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define TSRR_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define TSRR_ASSERT(lbl, clk, rst_n, prop)
`define TSRR_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/tsrr_pkg.sv =====
// Shared types and constants for the round-robin task slot scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tsrr_pkg;

	localparam int SlotsDef = 32;
	localparam int FuncW    = 2;
	localparam int KillW    = 6;
	localparam int StatusW  = 2;
	localparam int SlotW    = 5;
	localparam int LiveW    = 6;
	localparam int InDataW  = 8;
	localparam int OutDataW = 16;

	localparam logic [FuncW-1:0] FUNC_REG   = 2'd0;
	localparam logic [FuncW-1:0] FUNC_KILL  = 2'd1;
	localparam logic [FuncW-1:0] FUNC_SCHED = 2'd2;

	localparam logic [StatusW-1:0] ST_OK    = 2'd0;
	localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
	localparam logic [StatusW-1:0] ST_RANGE = 2'd2;
	localparam logic [StatusW-1:0] ST_NONE  = 2'd3;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} tsrr_cmd_t;

	typedef struct packed {
		logic scan_req;
		logic hit;
		logic last;
		logic out_free;
	} tsrr_stat_t;

endpackage

// ===== rtl/tsrr_ctrl.sv =====
// Sequencer for the task slot scheduler: accept, slot scan, result write.
// Depends on tsrr_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "task_slot_round_robin_core_assert.svh"

module tsrr_ctrl
	import tsrr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  tsrr_stat_t st,
	output tsrr_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= st.scan_req ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (st.hit || st.last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (st.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.step   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FINISH) && st.out_free;
	end

	`TSRR_ASSERT(a_scan_ends, clk, arst_n, (state_q == S_SCAN && st.last) |=> state_q != S_SCAN)
	`TSRR_ASSERT(a_direct_finish, clk, arst_n, (cmd.load && !st.scan_req) |=> state_q == S_FINISH)
	`TSRR_ASSERT(a_finish_free, clk, arst_n, cmd.finish |-> st.out_free)

endmodule

// ===== rtl/tsrr_dp.sv =====
// Datapath of the task slot scheduler: slot table, scan pointer, result register.
// Depends on tsrr_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "task_slot_round_robin_core_assert.svh"

module tsrr_dp
	import tsrr_pkg::*;
#(
	parameter int SLOTS = SlotsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FuncW-1:0]    func,
	input  logic [KillW-1:0]    kill_slot,
	input  tsrr_cmd_t           cmd,
	output tsrr_stat_t          st,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [StatusW-1:0]  status,
	output logic [SlotW-1:0]    slot,
	output logic [LiveW-1:0]    live_tasks
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);
	localparam logic [CW-1:0] SlotsC  = CW'(SLOTS);

	logic [SLOTS-1:0]   active_q;
	logic [IW-1:0]      current_q;
	logic [CW-1:0]      live_q;
	logic [FuncW-1:0]   func_q;
	logic [KillW-1:0]   kill_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      step_q;
	logic               found_q;
	logic               out_valid_q;
	logic [StatusW-1:0] status_q;
	logic [SlotW-1:0]   slot_q;
	logic [LiveW-1:0]   live_out_q;

	logic               want;
	logic               kill_in_range;
	logic [IW-1:0]      kill_idx;
	logic [IW-1:0]      sched_start;

	assign want          = (func_q == FUNC_SCHED);
	assign kill_in_range = ({1'b0, kill_q} < (KillW + 1)'(SLOTS));
	assign kill_idx      = kill_q[IW-1:0];
	assign sched_start   = (current_q == LastIdx) ? '0 : current_q + 1'b1;

	always_comb begin
		st.scan_req = (func == FUNC_SCHED) || ((func == FUNC_REG) && (live_q < SlotsC));
		st.hit      = (active_q[pos_q] == want);
		st.last     = (step_q == LastIdx);
		st.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			kill_q <= kill_slot;
			step_q <= '0;
			pos_q  <= (func == FUNC_SCHED) ? sched_start : live_q[IW-1:0];
		end else if (cmd.step && !st.hit) begin
			step_q <= step_q + 1'b1;
			pos_q  <= (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.step && st.hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			current_q   <= LastIdx;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				case (func_q)
					FUNC_REG: begin
						if (found_q) begin
							active_q[pos_q] <= 1'b1;
							live_q          <= live_q + 1'b1;
						end
					end
					FUNC_KILL: begin
						if (kill_in_range && active_q[kill_idx]) begin
							active_q[kill_idx] <= 1'b0;
							if (live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
						end
					end
					FUNC_SCHED: begin
						if (found_q) begin
							current_q <= pos_q;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q   <= ST_OK;
			slot_q     <= '0;
			live_out_q <= LiveW'(live_q);
			case (func_q)
				FUNC_REG: begin
					if (found_q) begin
						slot_q     <= SlotW'(pos_q);
						live_out_q <= LiveW'(live_q + 1'b1);
					end else begin
						status_q <= ST_FULL;
					end
				end
				FUNC_KILL: begin
					if (kill_in_range) begin
						slot_q <= SlotW'(kill_idx);
						if (active_q[kill_idx] && live_q != '0) begin
							live_out_q <= LiveW'(live_q - 1'b1);
						end
					end else begin
						status_q <= ST_RANGE;
					end
				end
				FUNC_SCHED: begin
					if (found_q) begin
						slot_q <= SlotW'(pos_q);
					end else begin
						status_q <= ST_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot       = slot_q;
	assign live_tasks = live_out_q;

	`TSRR_ASSERT(a_live_bound, clk, arst_n, live_q <= SlotsC)
	`TSRR_ASSERT(a_live_matches, clk, arst_n, $countones(active_q) == int'(live_q))
	`TSRR_ASSERT(a_current_bound, clk, arst_n, current_q <= LastIdx)

endmodule

// ===== rtl/task_slot_round_robin_core.sv =====
// Top level of the round-robin task slot scheduler.
// Depends on tsrr_pkg, tsrr_ctrl and tsrr_dp.
`timescale 1ns / 1ps

// Each input transfer is one request (register, kill or schedule) and yields
// exactly one output transfer. Register and schedule requests scan the slot
// table one slot per cycle before the result write; a table-full register, a
// kill and an unused code skip the scan and go straight to the result write.
// The slot table lives in flip-flops and is clear right after reset, so no
// start-up pass is needed. A finished result waits in the output register while
// the next request is accepted.
module task_slot_round_robin_core
	import tsrr_pkg::*;
#(
	parameter int SLOTS = SlotsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // func[1:0], kill_slot[7:2]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata    // status[1:0], slot[6:2], live_tasks[12:7], zero
);

	tsrr_cmd_t          cmd;
	tsrr_stat_t         st;
	logic [StatusW-1:0] status;
	logic [SlotW-1:0]   slot;
	logic [LiveW-1:0]   live_tasks;

	tsrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tsrr_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (s_tdata[FuncW-1:0]),
		.kill_slot  (s_tdata[FuncW+KillW-1:FuncW]),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (status),
		.slot       (slot),
		.live_tasks (live_tasks)
	);

	assign m_tdata = {3'b000, live_tasks, slot, status};

endmodule

// ===== tb/task_slot_round_robin_core_chk.sv =====
// Checker for the round-robin task slot scheduler: keeps its own slot table,
// predicts one answer per accepted request and compares the output transfers.
// Depends on tsrr_pkg only.
`timescale 1ns / 1ps

module task_slot_round_robin_core_chk
	import tsrr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	output int                  failures,
	output int                  pending,
	output int                  checked,
	output int                  full_seen,
	output int                  range_seen,
	output int                  none_seen
);

	localparam int NSLOTS = SlotsDef;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic [SlotW-1:0]   slot;
		logic [LiveW-1:0]   live;
	} sched_answer_t;

	bit            occupied [NSLOTS];
	int            cur_pos;
	int            live_cnt;
	sched_answer_t due_answers [$];
	sched_answer_t want;

	function automatic int find_slot(input int start, input bit busy);
		int pos;
		int n;
		pos = start % NSLOTS;
		for (n = 0; n < NSLOTS; n++) begin
			if (occupied[pos] == busy)
				return pos;
			pos = (pos + 1) % NSLOTS;
		end
		return NSLOTS;
	endfunction

	function automatic sched_answer_t serve_request(input logic [FuncW-1:0] op,
			input logic [KillW-1:0] target);
		sched_answer_t ans;
		int pos;
		ans.status = ST_OK;
		ans.slot = '0;
		case (op)
			FUNC_REG: begin
				if (live_cnt >= NSLOTS) begin
					ans.status = ST_FULL;
				end else begin
					pos = find_slot(live_cnt, 1'b0);
					if (pos < NSLOTS) begin
						occupied[pos] = 1'b1;
						live_cnt++;
						ans.slot = pos[SlotW-1:0];
					end else begin
						ans.status = ST_FULL;
					end
				end
			end
			FUNC_KILL: begin
				if (int'(target) >= NSLOTS) begin
					ans.status = ST_RANGE;
				end else begin
					if (occupied[target]) begin
						occupied[target] = 1'b0;
						if (live_cnt > 0)
							live_cnt--;
					end
					ans.slot = target[SlotW-1:0];
				end
			end
			FUNC_SCHED: begin
				pos = find_slot((cur_pos + 1) % NSLOTS, 1'b1);
				if (pos < NSLOTS) begin
					cur_pos = pos;
					ans.slot = pos[SlotW-1:0];
				end else begin
					ans.status = ST_NONE;
				end
			end
			default: begin
			end
		endcase
		ans.live = live_cnt[LiveW-1:0];
		return ans;
	endfunction

	// The result is compared before the request of the same edge is predicted,
	// so a transfer never meets its own request's answer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (occupied[i])
				occupied[i] = 1'b0;
			cur_pos = NSLOTS - 1;
			live_cnt = 0;
			due_answers.delete();
			failures = 0;
			pending = 0;
			checked = 0;
			full_seen = 0;
			range_seen = 0;
			none_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_answers.size() == 0) begin
					$error("result transfer 0x%h with no request outstanding", m_tdata);
					failures++;
				end else begin
					want = due_answers.pop_front();
					checked++;
					if (m_tdata[1:0] != want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, m_tdata[1:0]);
						failures++;
					end
					if (m_tdata[6:2] != want.slot) begin
						$error("slot mismatch: expected %0d, got %0d",
							want.slot, m_tdata[6:2]);
						failures++;
					end
					if (m_tdata[12:7] != want.live) begin
						$error("live_tasks mismatch: expected %0d, got %0d",
							want.live, m_tdata[12:7]);
						failures++;
					end
					if (m_tdata[OutDataW-1:13] != '0) begin
						$error("padding mismatch: expected 0, got %0d",
							m_tdata[OutDataW-1:13]);
						failures++;
					end
					case (want.status)
						ST_FULL:  full_seen++;
						ST_RANGE: range_seen++;
						ST_NONE:  none_seen++;
						default: begin
						end
					endcase
				end
			end
			if (s_tvalid && s_tready)
				due_answers.push_back(serve_request(s_tdata[1:0], s_tdata[7:2]));
			pending = due_answers.size();
		end
	end

endmodule

// ===== tb/task_slot_round_robin_core_tb.sv =====
// Top of the round-robin task slot scheduler testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict.
// Depends on tsrr_pkg, task_slot_round_robin_core and task_slot_round_robin_core_chk.
`timescale 1ns / 1ps

module task_slot_round_robin_core_tb;
	import tsrr_pkg::*;

	localparam logic [FuncW-1:0] FUNC_SPARE = 2'd3;
	localparam int ITEMS        = 1500;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = SlotsDef + 16;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                s_fire;

	int failures;
	int pending;
	int checked;
	int full_seen;
	int range_seen;
	int none_seen;
	int sent;
	int directed;
	int burst_left;
	int quiet_cycles;
	int rx_mode;
	int rx_left;

	task_slot_round_robin_core #(
		.SLOTS(SlotsDef)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	task_slot_round_robin_core_chk u_sched_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.failures(failures),
		.pending(pending),
		.checked(checked),
		.full_seen(full_seen),
		.range_seen(range_seen),
		.none_seen(none_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s_fire <= 1'b0;
		else
			s_fire <= s_tvalid && s_tready;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles.", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// The receiver switches between always ready, random, periodic and
	// long-stall patterns.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end
		rx_left--;
		case (rx_mode)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = (rx_left % 5 == 0);
			default: m_tready = ($urandom_range(0, 29) == 0);
		endcase
	end

	task automatic send_request(input logic [FuncW-1:0] op, input logic [KillW-1:0] target);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid = 1'b1;
		s_tdata = {target, op};
		do
			@(negedge clk);
		while (!s_fire);
		burst_left--;
		sent++;
	endtask

	initial begin
		int regime;
		int regime_left;
		int roll;
		int sweep;
		logic [FuncW-1:0] op;
		logic [KillW-1:0] target;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		regime_left = 0;
		sweep = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Empty table, kill range limits, free-slot kill and the unused code.
		send_request(FUNC_SCHED, 6'd0);
		send_request(FUNC_KILL, 6'd63);
		send_request(FUNC_KILL, 6'd32);
		send_request(FUNC_KILL, 6'd31);
		send_request(FUNC_SPARE, 6'd63);
		repeat (3) send_request(FUNC_REG, 6'd0);
		repeat (4) send_request(FUNC_SCHED, 6'd0);
		send_request(FUNC_KILL, 6'd0);
		send_request(FUNC_SCHED, 6'd0);
		send_request(FUNC_REG, 6'd42);
		send_request(FUNC_KILL, 6'd1);
		send_request(FUNC_KILL, 6'd2);
		send_request(FUNC_KILL, 6'd3);
		send_request(FUNC_KILL, 6'd3);
		send_request(FUNC_SCHED, 6'd0);
		send_request(FUNC_REG, 6'd63);
		directed = sent;

		// Fill, drain, schedule-heavy and noise phases so that the table often
		// runs full and often runs empty.
		repeat (ITEMS) begin
			if (regime_left == 0) begin
				regime = $urandom_range(0, 3);
				regime_left = $urandom_range(20, 80);
			end
			regime_left--;
			roll = $urandom_range(0, 99);
			target = ($urandom_range(0, 7) == 0) ? KillW'($urandom_range(0, 63))
				: KillW'($urandom_range(0, 31));
			case (regime)
				0: begin
					if (roll < 70)
						op = FUNC_REG;
					else if (roll < 80)
						op = FUNC_KILL;
					else if (roll < 98)
						op = FUNC_SCHED;
					else
						op = FUNC_SPARE;
				end
				1: begin
					if (roll < 65) begin
						op = FUNC_KILL;
						target = KillW'(sweep);
						sweep = (sweep + 1) % 40;
					end else if (roll < 80) begin
						op = FUNC_SCHED;
					end else if (roll < 98) begin
						op = FUNC_REG;
					end else begin
						op = FUNC_SPARE;
					end
				end
				2: begin
					if (roll < 60)
						op = FUNC_SCHED;
					else if (roll < 80)
						op = FUNC_REG;
					else if (roll < 98)
						op = FUNC_KILL;
					else
						op = FUNC_SPARE;
				end
				default: begin
					op = FuncW'($urandom_range(0, 3));
					target = KillW'($urandom_range(0, 63));
				end
			endcase
			send_request(op, target);
		end
		s_tvalid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d requests (%0d directed) and compared %0d answers.",
			sent, directed, checked);
		$display("Answers included %0d table full, %0d out of range, %0d with no active task.",
			full_seen, range_seen, none_seen);
		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsrr_pkg.sv
rtl/tsrr_ctrl.sv
rtl/tsrr_dp.sv
rtl/task_slot_round_robin_core.sv
tb/task_slot_round_robin_core_chk.sv
tb/task_slot_round_robin_core_tb.sv
